// File: rtl/core/ssl_pkg.sv
`default_nettype none
package ssl_pkg;

  localparam int SLOTS        = 8;
  localparam int RING_DEPTH   = 96;
  localparam int REPORT_BYTES = 10;

  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int POS_W    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SAMPLE_DEPTH = SLOTS * RING_DEPTH;
  localparam int SADDR_W  = $clog2(SAMPLE_DEPTH);
  localparam int RPT_BYTES_IN = 10;
  localparam int SAMPLE_W = 96;

  localparam logic [15:0] SINK_PROTO    = 16'hC00F;
  localparam logic [6:0]  HDR_BYTES     = 7'd13;
  localparam logic [31:0] TIMEOUT_RESET = 32'd60000;

  localparam logic [1:0] OP_MSG   = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [7:0] CMD_ADV_REQ  = 8'd0;
  localparam logic [7:0] CMD_PAIR_REQ = 8'd2;
  localparam logic [7:0] CMD_DATA     = 8'd4;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_ADV     = 2'd1;
  localparam logic [1:0] KIND_CONFIRM = 2'd2;

  localparam logic [2:0] OC_HANDLED   = 3'd0;
  localparam logic [2:0] OC_BAD_HDR   = 3'd1;
  localparam logic [2:0] OC_PAIR_FULL = 3'd2;
  localparam logic [2:0] OC_UNKNOWN   = 3'd3;
  localparam logic [2:0] OC_REC_FULL  = 3'd4;
  localparam logic [2:0] OC_IGNORED   = 3'd5;
  localparam logic [2:0] OC_TICK_DONE = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ROW_RD,
    ST_ROW_EV,
    ST_DONE
  } ssl_state_t;

  typedef struct packed {
    logic [63:0] eui;
    logic [15:0] short_id;
    logic [31:0] last_ms;
    logic [79:0] report;
  } slot_row_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [6:0]  msg_length;
    logic [15:0] protocol_id;
    logic [7:0]  command;
    logic [63:0] sender_eui;
    logic [15:0] source_id;
    logic [63:0] data_low;
    logic [15:0] data_high;
    logic [31:0] now_ms;
    logic        confirm_sent;
  } item_t;

  typedef struct packed {
    logic [1:0]  reply_kind;
    logic [15:0] reply_dest;
    logic [2:0]  outcome;
    logic [2:0]  slot;
    logic [2:0]  record;
    logic [6:0]  sample_pos;
    logic [7:0]  expired_mask;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/core/ssl_if.sv
`default_nettype none
interface ssl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [6:0]  msg_length;
  logic [15:0] protocol_id;
  logic [7:0]  command;
  logic [63:0] sender_eui;
  logic [15:0] source_id;
  logic [63:0] data_low;
  logic [15:0] data_high;
  logic [31:0] now_ms;
  logic        confirm_sent;

  modport source (output valid, operation, msg_length, protocol_id, command, sender_eui,
                  source_id, data_low, data_high, now_ms, confirm_sent, input ready);
  modport sink (input valid, operation, msg_length, protocol_id, command, sender_eui,
                source_id, data_low, data_high, now_ms, confirm_sent, output ready);
endinterface

interface ssl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reply_kind;
  logic [15:0] reply_dest;
  logic [2:0]  outcome;
  logic [2:0]  slot;
  logic [2:0]  record;
  logic [6:0]  sample_pos;
  logic [7:0]  expired_mask;

  modport source (output valid, reply_kind, reply_dest, outcome, slot, record, sample_pos,
                  expired_mask, input ready);
  modport sink (input valid, reply_kind, reply_dest, outcome, slot, record, sample_pos,
                expired_mask, output ready);
endinterface
`default_nettype wire

// File: rtl/core/ssl_slot_ram.sv
`default_nettype none
module ssl_slot_ram (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      rd_en,
  input  wire logic [ssl_pkg::SLOT_W-1:0] rd_addr,
  input  wire logic                      wr_en,
  input  wire logic [ssl_pkg::SLOT_W-1:0] wr_addr,
  input  wire ssl_pkg::slot_row_t        wr_row,
  output ssl_pkg::slot_row_t             rd_row
);
  import ssl_pkg::*;

  slot_row_t         mem [SLOTS];
  slot_row_t         rd_q_r;
  logic              rd_written_r;
  logic [SLOTS-1:0]  written_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r    <= '0;
      rd_written_r <= 1'b0;
    end else begin
      if (wr_en) begin
        written_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written_r <= written_r[rd_addr];
      end
    end
  end

  assign rd_row = rd_written_r ? rd_q_r : '0;

  a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en)) else $error("slot ram read and write overlap");
  a_written_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> written_r[$past(wr_addr)]) else $error("written flag lost");
  a_written_only_grows: assert property (@(posedge clk) disable iff (!rst_n)
    !wr_en |=> written_r == $past(written_r)) else $error("written flags changed");

endmodule
`default_nettype wire

// File: rtl/core/ssl_sample_ram.sv
`default_nettype none
module ssl_sample_ram (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [ssl_pkg::SADDR_W-1:0] wr_addr,
  input  wire logic [ssl_pkg::SAMPLE_W-1:0] wr_data
);
  import ssl_pkg::*;

  logic [SAMPLE_W-1:0] mem [SAMPLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/sensor_sink_pair_and_log_top.sv
// Sensor sink: pairing table, report store and per-node sample log.
// in_chan (valid/ready) takes one item: a radio message, a timer tick or a
// network-down clear. out_chan (valid/ready) gives exactly one result item per
// input item, in order. cfg_we/cfg_wdata write the expiry timeout (ms).
// One item is worked on at a time. Clear, dropped and ignored messages and
// advertise requests go from idle straight to the done state, from which
// out_chan.valid is registered. Ticks, pair requests and data reports scan the
// slot RAM one entry a cycle (one registered read port): ticks, full pair
// tables, unsent confirms and unknown senders finish after the scan. Pair and
// data items that hit a slot re-read it and write it back; data items also
// write the sample log unless the record table is full. The scan of the slot
// RAM sets the rate.
// A finished result sits in the output register while the next item is
// accepted and worked on; a stalled receiver blocks only when a second result
// is ready to leave before the first is taken.
// Reset (synchronous, active low) clears all slot marks, the record table and
// the timeout (back to 60000). No clearing pass is needed: untouched slots
// read as zero, and the sample log is write-only.
`default_nettype none
module sensor_sink_pair_and_log_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ssl_in_if.sink     in_chan,
  ssl_out_if.source  out_chan,
  input  wire logic  cfg_we,
  input  wire logic [31:0] cfg_wdata
);
  import ssl_pkg::*;

  ssl_state_t state_r, state_nxt;

  item_t               item_r;
  result_t             res_r;
  result_t             out_r;
  logic                out_valid_r;
  logic [31:0]         timeout_r;
  logic [SLOTS-1:0]    slot_valid_r;
  logic [CNT_W-1:0]    scan_cnt_r;
  logic [SLOTS-1:0]    mask_r;
  logic                pm_found_r, free_found_r, dm_found_r;
  logic [SLOT_W-1:0]   pm_idx_r, free_idx_r, dm_idx_r;
  logic [SLOT_W-1:0]   sel_slot_r;
  logic [CNT_W-1:0]    rec_count_r;
  logic [31:0]         rec_key_r [SLOTS];
  logic [POS_W-1:0]    rec_pos_r [SLOTS];

  // slot ram ports
  logic                ram_rd_en, ram_wr_en;
  logic [SLOT_W-1:0]   ram_rd_addr;
  slot_row_t           ram_wr_row, ram_rd_row;

  // sample ram ports
  logic                smp_we;
  logic [SADDR_W-1:0]  smp_addr;
  logic [SAMPLE_W-1:0] smp_data;

  logic                in_acc;
  logic                ev_on;
  logic [SLOT_W-1:0]   e_idx;
  logic                cur_valid, cur_pm, cur_free, cur_dm, cur_exp;
  logic                scan_last;
  logic                pm_f, free_f, dm_f;
  logic [SLOT_W-1:0]   pm_idx_f, free_idx_f, dm_idx_f;
  logic                pair_any;
  logic [SLOT_W-1:0]   pair_pick;
  logic                is_data;
  logic                is_pair;
  logic                is_tick;
  logic [6:0]          rpt_n;
  logic [79:0]         new_bytes;
  logic [79:0]         merged;
  logic                rec_hit, rec_full;
  logic [SLOT_W-1:0]   rec_hit_idx, rec_sel;
  logic [POS_W-1:0]    cur_pos, next_pos;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign is_tick       = (item_r.operation == OP_TICK);
  assign is_pair       = (item_r.command == CMD_PAIR_REQ);
  assign is_data       = (item_r.command == CMD_DATA);

  // scan evaluation of the entry read in the previous cycle
  always_comb begin
    ev_on     = (state_r == ST_SCAN) && (scan_cnt_r != '0);
    e_idx     = SLOT_W'(scan_cnt_r - CNT_W'(1));
    cur_valid = slot_valid_r[e_idx];
    cur_pm    = ev_on && cur_valid && (ram_rd_row.eui == item_r.sender_eui);
    cur_free  = ev_on && !cur_valid;
    cur_dm    = ev_on && (ram_rd_row.eui == item_r.sender_eui);
    cur_exp   = ev_on && cur_valid &&
                ((item_r.now_ms - ram_rd_row.last_ms) > timeout_r);
    scan_last = (state_r == ST_SCAN) && (scan_cnt_r == CNT_W'(SLOTS));
    pm_f       = pm_found_r | cur_pm;
    pm_idx_f   = pm_found_r ? pm_idx_r : e_idx;
    free_f     = free_found_r | cur_free;
    free_idx_f = free_found_r ? free_idx_r : e_idx;
    dm_f       = dm_found_r | cur_dm;
    dm_idx_f   = dm_found_r ? dm_idx_r : e_idx;
    pair_any   = pm_f | free_f;
    pair_pick  = pm_f ? pm_idx_f : free_idx_f;
  end

  // report merge and record lookup for a data item
  always_comb begin
    rpt_n = item_r.msg_length - HDR_BYTES;
    if (rpt_n > 7'(REPORT_BYTES)) begin
      rpt_n = 7'(REPORT_BYTES);
    end
    new_bytes = {item_r.data_high, item_r.data_low};
    for (int b = 0; b < RPT_BYTES_IN; b++) begin
      merged[8*b +: 8] = (7'(b) < rpt_n) ? new_bytes[8*b +: 8] : ram_rd_row.report[8*b +: 8];
    end
    rec_hit     = 1'b0;
    rec_hit_idx = '0;
    for (int r = 0; r < SLOTS; r++) begin
      if (!rec_hit && (CNT_W'(r) < rec_count_r) &&
          (rec_key_r[r] == item_r.sender_eui[31:0])) begin
        rec_hit     = 1'b1;
        rec_hit_idx = SLOT_W'(r);
      end
    end
    rec_full = !rec_hit && (rec_count_r == CNT_W'(SLOTS));
    rec_sel  = rec_hit ? rec_hit_idx : rec_count_r[SLOT_W-1:0];
    cur_pos  = rec_hit ? rec_pos_r[rec_hit_idx] : '0;
    next_pos = (cur_pos == POS_W'(RING_DEPTH - 1)) ? '0 : cur_pos + POS_W'(1);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_chan.operation == OP_TICK) begin
            state_nxt = ST_SCAN;
          end else if ((in_chan.operation == OP_MSG) &&
                       (in_chan.msg_length >= HDR_BYTES) &&
                       (in_chan.protocol_id == SINK_PROTO) &&
                       (in_chan.command inside {CMD_PAIR_REQ, CMD_DATA})) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          if (is_tick) begin
            state_nxt = ST_DONE;
          end else if (is_pair) begin
            state_nxt = (pair_any && item_r.confirm_sent) ? ST_ROW_RD : ST_DONE;
          end else begin
            state_nxt = dm_f ? ST_ROW_RD : ST_DONE;
          end
        end
      end
      ST_ROW_RD: state_nxt = ST_ROW_EV;
      ST_ROW_EV: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    ram_rd_en   = 1'b0;
    ram_rd_addr = scan_cnt_r[SLOT_W-1:0];
    ram_wr_en   = 1'b0;
    ram_wr_row  = ram_rd_row;
    smp_we      = 1'b0;
    smp_addr    = SADDR_W'(rec_sel) * SADDR_W'(RING_DEPTH) + SADDR_W'(cur_pos);
    smp_data    = {item_r.now_ms[15:0], merged};
    case (state_r)
      ST_SCAN: begin
        ram_rd_en = (scan_cnt_r < CNT_W'(SLOTS));
      end
      ST_ROW_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = sel_slot_r;
      end
      ST_ROW_EV: begin
        ram_wr_en = 1'b1;
        ram_wr_row.last_ms = item_r.now_ms;
        if (is_data) begin
          ram_wr_row.report = merged;
          smp_we            = !rec_full;
        end else begin
          ram_wr_row.eui      = item_r.sender_eui;
          ram_wr_row.short_id = item_r.source_id;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      timeout_r    <= TIMEOUT_RESET;
      slot_valid_r <= '0;
      rec_count_r  <= '0;
      for (int r = 0; r < SLOTS; r++) begin
        rec_key_r[r] <= '0;
        rec_pos_r[r] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
      if (state_r == ST_DONE && (!out_valid_r || out_chan.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc && in_chan.operation == OP_CLEAR) begin
        slot_valid_r <= '0;
      end
      if (scan_last) begin
        if (is_tick) begin
          slot_valid_r <= slot_valid_r & ~(mask_r | (SLOTS'(cur_exp) << e_idx));
        end else if (is_pair && pair_any && item_r.confirm_sent) begin
          slot_valid_r[pair_pick] <= 1'b1;
        end
      end
      if (smp_we) begin
        rec_pos_r[rec_sel] <= next_pos;
        if (!rec_hit) begin
          rec_key_r[rec_sel] <= item_r.sender_eui[31:0];
          rec_count_r        <= rec_count_r + CNT_W'(1);
        end
      end
    end
  end

  // item, scan and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r       <= in_chan.operation == OP_MSG ? {in_chan.operation, in_chan.msg_length,
                      in_chan.protocol_id, in_chan.command, in_chan.sender_eui,
                      in_chan.source_id, in_chan.data_low, in_chan.data_high,
                      in_chan.now_ms, in_chan.confirm_sent}
                    : {in_chan.operation, in_chan.msg_length, in_chan.protocol_id,
                       in_chan.command, in_chan.sender_eui, in_chan.source_id,
                       in_chan.data_low, in_chan.data_high, in_chan.now_ms,
                       in_chan.confirm_sent};
      scan_cnt_r   <= '0;
      mask_r       <= '0;
      pm_found_r   <= 1'b0;
      free_found_r <= 1'b0;
      dm_found_r   <= 1'b0;
      res_r        <= '0;
      case (in_chan.operation)
        OP_MSG: begin
          if ((in_chan.msg_length < HDR_BYTES) || (in_chan.protocol_id != SINK_PROTO)) begin
            res_r.outcome <= OC_BAD_HDR;
          end else if (in_chan.command == CMD_ADV_REQ) begin
            res_r.reply_kind <= KIND_ADV;
            res_r.reply_dest <= in_chan.source_id;
          end else if (!(in_chan.command inside {CMD_PAIR_REQ, CMD_DATA})) begin
            res_r.outcome <= OC_IGNORED;
          end
        end
        OP_TICK:  res_r.outcome <= OC_TICK_DONE;
        OP_CLEAR: begin
          res_r.outcome      <= OC_TICK_DONE;
          res_r.expired_mask <= 8'(slot_valid_r);
        end
        default:  res_r.outcome <= OC_IGNORED;
      endcase
    end
    if (state_r == ST_SCAN) begin
      scan_cnt_r <= scan_cnt_r + CNT_W'(1);
      if (cur_exp) begin
        mask_r[e_idx] <= 1'b1;
      end
      if (cur_pm && !pm_found_r) begin
        pm_found_r <= 1'b1;
        pm_idx_r   <= e_idx;
      end
      if (cur_free && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= e_idx;
      end
      if (cur_dm && !dm_found_r) begin
        dm_found_r <= 1'b1;
        dm_idx_r   <= e_idx;
      end
    end
    if (scan_last) begin
      if (is_tick) begin
        res_r.expired_mask <= 8'(mask_r | (SLOTS'(cur_exp) << e_idx));
      end else if (is_pair) begin
        sel_slot_r <= pair_pick;
        if (pair_any) begin
          res_r.reply_kind <= KIND_CONFIRM;
          res_r.reply_dest <= item_r.source_id;
          res_r.slot       <= 3'(pair_pick);
        end else begin
          res_r.outcome <= OC_PAIR_FULL;
        end
      end else begin
        sel_slot_r <= dm_idx_f;
        if (dm_f) begin
          res_r.slot <= 3'(dm_idx_f);
        end else begin
          res_r.outcome <= OC_UNKNOWN;
        end
      end
    end
    if (state_r == ST_ROW_EV && is_data) begin
      if (rec_full) begin
        res_r.outcome <= OC_REC_FULL;
      end else begin
        res_r.record     <= 3'(rec_sel);
        res_r.sample_pos <= 7'(cur_pos);
      end
    end
    if (state_r == ST_DONE && (!out_valid_r || out_chan.ready)) begin
      out_r <= res_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.reply_kind   = out_r.reply_kind;
  assign out_chan.reply_dest   = out_r.reply_dest;
  assign out_chan.outcome      = out_r.outcome;
  assign out_chan.slot         = out_r.slot;
  assign out_chan.record       = out_r.record;
  assign out_chan.sample_pos   = out_r.sample_pos;
  assign out_chan.expired_mask = out_r.expired_mask;

  ssl_slot_ram u_slot_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .wr_en   (ram_wr_en),
    .wr_addr (sel_slot_r),
    .wr_row  (ram_wr_row),
    .rd_row  (ram_rd_row)
  );

  ssl_sample_ram u_sample_ram (
    .clk     (clk),
    .wr_en   (smp_we),
    .wr_addr (smp_addr),
    .wr_data (smp_data)
  );

  a_row_ev_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROW_EV |=> state_r == ST_DONE) else $error("write-back not followed by done");
  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    scan_last |=> state_r != ST_SCAN) else $error("scan ran past last slot");
  a_rec_count: assert property (@(posedge clk) disable iff (!rst_n)
    rec_count_r <= CNT_W'(SLOTS)) else $error("record count overflow");
  a_sample_pos: assert property (@(posedge clk) disable iff (!rst_n)
    smp_we |-> cur_pos < POS_W'(RING_DEPTH)) else $error("ring position out of range");
  a_sample_rec: assert property (@(posedge clk) disable iff (!rst_n)
    smp_we |=> rec_count_r != '0) else $error("sample written with no record");

endmodule
`default_nettype wire
